>>> rtl/wsdu_pkg.sv
`default_nettype none

package wsdu_pkg;

  localparam logic [6:0] LEN_MASK    = 7'h7F;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_KEY  = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       empty;
    logic       status;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/wsdu_parser.sv
`default_nettype none

module wsdu_parser (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  wire        [7:0] rx_byte,
  input  wire              frame_start,
  output wsdu_pkg::result_t result
);

  wsdu_pkg::phase_t phase, phase_next;
  logic [1:0]  header_position, header_position_next;
  logic [15:0] payload_length, payload_length_next;
  logic [7:0]  mask_key [4];
  logic [15:0] payload_count, payload_count_next;
  logic        long_length_seen, long_length_seen_next;
  logic        key_write;

  logic [6:0]  code;
  logic [15:0] count_inc;

  assign code      = rx_byte[6:0] & wsdu_pkg::LEN_MASK;
  assign count_inc = payload_count + 16'd1;

  always_comb begin
    phase_next            = phase;
    header_position_next  = header_position;
    payload_length_next   = payload_length;
    payload_count_next    = payload_count;
    long_length_seen_next = long_length_seen;
    key_write             = 1'b0;
    result                = '0;
    if (frame_start) begin
      phase_next            = wsdu_pkg::PH_LEN;
      header_position_next  = 2'd0;
      payload_length_next   = 16'd0;
      payload_count_next    = 16'd0;
      long_length_seen_next = 1'b0;
    end else begin
      case (phase)
        wsdu_pkg::PH_IDLE: begin
        end
        wsdu_pkg::PH_LEN: begin
          header_position_next = 2'd0;
          if (code == wsdu_pkg::LEN_CODE_16) begin
            phase_next = wsdu_pkg::PH_EXT;
          end else if (code == wsdu_pkg::LEN_CODE_64) begin
            long_length_seen_next = 1'b1;
            payload_length_next   = 16'd0;
            phase_next            = wsdu_pkg::PH_SKIP;
          end else begin
            payload_length_next = {9'd0, code};
            phase_next          = wsdu_pkg::PH_KEY;
          end
        end
        wsdu_pkg::PH_EXT: begin
          if (header_position == 2'd0) begin
            payload_length_next  = {rx_byte, 8'd0};
            header_position_next = 2'd1;
          end else begin
            payload_length_next  = payload_length | {8'd0, rx_byte};
            header_position_next = 2'd0;
            phase_next           = wsdu_pkg::PH_KEY;
          end
        end
        wsdu_pkg::PH_SKIP: begin
          header_position_next = header_position + 2'd1;
          if (header_position == 2'd3) begin
            phase_next = wsdu_pkg::PH_KEY;
          end
        end
        wsdu_pkg::PH_KEY: begin
          key_write            = 1'b1;
          header_position_next = header_position + 2'd1;
          if (header_position == 2'd3) begin
            payload_count_next = 16'd0;
            if (payload_length == 16'd0) begin
              phase_next    = wsdu_pkg::PH_IDLE;
              result.valid  = 1'b1;
              result.last   = 1'b1;
              result.empty  = 1'b1;
              result.status = long_length_seen;
            end else begin
              phase_next = wsdu_pkg::PH_DATA;
            end
          end
        end
        wsdu_pkg::PH_DATA: begin
          payload_count_next = count_inc;
          result.valid       = 1'b1;
          result.data        = rx_byte ^ mask_key[payload_count[1:0]];
          result.last        = (count_inc == payload_length);
          if (count_inc == payload_length) begin
            phase_next = wsdu_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = wsdu_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wsdu_pkg::PH_IDLE;
      header_position  <= 2'd0;
      payload_length   <= 16'd0;
      payload_count    <= 16'd0;
      long_length_seen <= 1'b0;
      mask_key         <= '{default: 8'd0};
    end else if (accept) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      payload_length   <= payload_length_next;
      payload_count    <= payload_count_next;
      long_length_seen <= long_length_seen_next;
      if (key_write) begin
        mask_key[header_position] <= rx_byte;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/websocket_frame_deframer_unmask_top.sv
`default_nettype none

// channel | handshake          | beat contents
// --------+--------------------+------------------------------------------------
// in      | in_valid/in_ready  | rx_byte, frame_start
// out     | out_valid/out_ready| payload_byte, last_byte, empty_frame, frame_status
//
// One input beat per cycle while in_ready is high; a result appears in the output
// register in the cycle after the beat that causes it, decoded by the parser.
// in_ready is high whenever the output register is empty or being drained.
// Synchronous reset clears the parse state, the key and the output valid.
// A stalled output holds its beat and blocks further input until taken.

module websocket_frame_deframer_unmask_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] rx_byte,
  input  wire        frame_start,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] payload_byte,
  output logic       last_byte,
  output logic       empty_frame,
  output logic       frame_status
);

  wsdu_pkg::result_t result;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  wsdu_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      payload_byte <= result.data;
      last_byte    <= result.last;
      empty_frame  <= result.empty;
      frame_status <= result.status;
    end
  end

endmodule

`default_nettype wire
